@@ rtl/ic_pkg.sv @@
// Package for the inversion counter: shared constants, defaults and the
// control structs passed between the top level and the merge sequencer.
// No dependencies.
package ic_pkg;

    localparam int MAX_ITEMS_DEF  = 4096;
    localparam int VALUE_BITS_DEF = 32;

    // Result field: saturating pair count plus the overflow flag
    localparam int          COUNT_W   = 23;
    localparam logic [22:0] COUNT_MAX = 23'h7FFFFF;
    localparam int          OUT_DW    = 24;

    // Top level to sequencer
    typedef struct packed {
        logic start;   // begin sorting the stored run
        logic ack;     // result taken, release the sequencer
    } t_seq_cmd;

    // Sequencer to top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

    // Buffer steering from the sequencer
    typedef struct packed {
        logic rd_src_b;   // source of the current pass is buffer B
        logic wr_en;      // write one merged element
        logic wr_dst_b;   // destination of the current pass is buffer B
    } t_mem_ctl;

endpackage

@@ rtl/ic_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ic_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ic_merge_seq.sv @@
// Bottom-up merge sort sequencer with one shared compare unit and a
// saturating inversion accumulator. Ping-pongs between two buffers.
// Depends on ic_pkg.
module ic_merge_seq #(
    parameter  int MAX_ITEMS  = ic_pkg::MAX_ITEMS_DEF,
    parameter  int VALUE_BITS = ic_pkg::VALUE_BITS_DEF,
    localparam int AW         = $clog2(MAX_ITEMS),
    localparam int LW         = $clog2(MAX_ITEMS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ic_pkg::t_seq_cmd           i_cmd,
    input  logic [LW-1:0]              i_len,
    input  logic [VALUE_BITS-1:0]      i_rd_data,
    output logic [AW-1:0]              o_rd_addr,
    output logic [AW-1:0]              o_wr_addr,
    output logic [VALUE_BITS-1:0]      o_wr_data,
    output ic_pkg::t_mem_ctl           o_mem,
    output ic_pkg::t_seq_stat          o_stat,
    output logic [ic_pkg::COUNT_W-1:0] o_count
);

    localparam int PW = LW + 2;
    localparam int SW = ((ic_pkg::COUNT_W > LW) ? ic_pkg::COUNT_W : LW) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_INITL = 3'd3;
    localparam logic [2:0] S_CAPL  = 3'd4;
    localparam logic [2:0] S_CAPR  = 3'd5;
    localparam logic [2:0] S_STEP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [LW-1:0]               r_len, n_len;
    logic [PW-1:0]               r_width, n_width;
    logic [PW-1:0]               r_lo, n_lo;
    logic [LW-1:0]               r_mid, n_mid;
    logic [LW-1:0]               r_hi, n_hi;
    logic [LW-1:0]               r_i, n_i;
    logic [LW-1:0]               r_j, n_j;
    logic [LW-1:0]               r_k, n_k;
    logic [VALUE_BITS-1:0]       r_left, n_left;
    logic [VALUE_BITS-1:0]       r_right, n_right;
    logic                        r_src_b, n_src_b;
    logic [ic_pkg::COUNT_W-1:0]  r_count, n_count;

    logic [PW-1:0]               w_len_ext;
    logic [PW-1:0]               w_lo_plus_w;
    logic [PW-1:0]               w_mid_plus_w;
    logic [LW-1:0]               w_mid_sel;
    logic [LW-1:0]               w_hi_sel;
    logic                        w_left_live;
    logic                        w_right_live;
    logic                        w_take_right;
    logic [LW-1:0]               w_i_inc;
    logic [LW-1:0]               w_j_inc;
    logic [LW-1:0]               w_remain;
    logic [SW-1:0]               w_sum;
    logic [ic_pkg::COUNT_W-1:0]  w_sat;
    logic                        w_wr_en;

    // Run bounds: clip each run end at the stored length
    assign w_len_ext    = PW'(r_len);
    assign w_lo_plus_w  = r_lo + r_width;
    assign w_mid_plus_w = PW'(r_mid) + r_width;
    assign w_mid_sel    = (w_lo_plus_w < w_len_ext) ? w_lo_plus_w[LW-1:0] : r_len;
    assign w_hi_sel     = (w_mid_plus_w < w_len_ext) ? w_mid_plus_w[LW-1:0] : r_len;

    // Shared compare: strictly greater left head yields to the right head
    assign w_left_live  = r_i < r_mid;
    assign w_right_live = r_j < r_hi;
    assign w_take_right = w_right_live &&
                          (!w_left_live || ($signed(r_left) > $signed(r_right)));

    assign w_i_inc  = r_i + LW'(1);
    assign w_j_inc  = r_j + LW'(1);
    assign w_remain = r_mid - r_i;
    assign w_sum    = SW'(r_count) + SW'(w_remain);
    assign w_sat    = (w_sum > SW'(ic_pkg::COUNT_MAX)) ? ic_pkg::COUNT_MAX
                                                       : w_sum[ic_pkg::COUNT_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_width   = r_width;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_left    = r_left;
        n_right   = r_right;
        n_src_b   = r_src_b;
        n_count   = r_count;
        o_rd_addr = r_i[AW-1:0];
        w_wr_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_len   = i_len;
                    n_width = PW'(1);
                    n_src_b = 1'b0;
                    n_count = '0;
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (r_width >= w_len_ext) begin
                    n_state = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // Prefetch the left head of the run while bounds settle
                o_rd_addr = r_lo[AW-1:0];
                if (r_lo >= w_len_ext) begin
                    n_width = r_width << 1;
                    n_src_b = !r_src_b;
                    n_state = S_PASS;
                end else begin
                    n_mid   = w_mid_sel;
                    n_i     = r_lo[LW-1:0];
                    n_j     = w_mid_sel;
                    n_k     = r_lo[LW-1:0];
                    n_state = S_INITL;
                end
            end
            S_INITL: begin
                n_left    = i_rd_data;
                o_rd_addr = r_j[AW-1:0];
                n_hi      = w_hi_sel;
                n_state   = S_CAPR;
            end
            S_CAPL: begin
                n_left  = i_rd_data;
                n_state = S_STEP;
            end
            S_CAPR: begin
                n_right = i_rd_data;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (!w_left_live && !w_right_live) begin
                    n_lo    = r_lo + (r_width << 1);
                    n_state = S_RUN;
                end else begin
                    w_wr_en = 1'b1;
                    n_k     = r_k + LW'(1);
                    if (w_take_right) begin
                        n_j       = w_j_inc;
                        o_rd_addr = w_j_inc[AW-1:0];
                        if (w_left_live) begin
                            n_count = w_sat;
                        end
                        n_state   = S_CAPR;
                    end else begin
                        n_i       = w_i_inc;
                        o_rd_addr = w_i_inc[AW-1:0];
                        n_state   = S_CAPL;
                    end
                end
            end
            S_DONE: begin
                if (i_cmd.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_left  <= n_left;
        r_right <= n_right;
        r_src_b <= n_src_b;
        r_count <= n_count;
    end

    assign o_wr_addr      = r_k[AW-1:0];
    assign o_wr_data      = w_take_right ? r_right : r_left;
    assign o_mem.rd_src_b = r_src_b;
    assign o_mem.wr_en    = w_wr_en;
    assign o_mem.wr_dst_b = !r_src_b;
    assign o_stat.busy    = (r_state != S_IDLE);
    assign o_stat.done    = (r_state == S_DONE);
    assign o_count        = r_count;

endmodule

@@ rtl/inversion_counter.sv @@
// Inversion counter top level: stream ports, load control, two element
// buffers and the result register around the merge sort sequencer.
// Depends on ic_pkg, ic_ram and ic_merge_seq.
//
//   Channel      Direction  Payload (low bit first)           Meaning
//   s_axis       in         tdata: value; tlast: last         one sequence element
//   m_axis       out        tdata: inversion_count,overflowed one result per sequence
//
// Loading accepts one element per cycle in the load phase. The element
// marked last starts the sort through a hand-off state: ceil(log2 n) passes
// over the stored n elements, each pass paced by the single read port of
// the source buffer feeding one shared compare unit (each merged element is
// written in a step state and the next head captured in a capture state;
// each run is set up in run and head capture states and closed by a step).
// A closing pass check and the done state follow; the result register
// loads when the done state is acknowledged, once the output register is free.
// Reset clears only control state; no buffer clearing pass is needed since
// only elements of the current sequence are ever read. The input stalls
// for the whole sort; the sort's result hand-over waits while a previous
// result waits on m_axis, but loading of the next sequence continues.
module inversion_counter #(
    parameter  int MAX_ITEMS  = ic_pkg::MAX_ITEMS_DEF,
    parameter  int VALUE_BITS = ic_pkg::VALUE_BITS_DEF,
    localparam int DW         = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [DW-1:0]             i_s_axis_tdata,   // [VALUE_BITS-1:0] value
    input  logic                      i_s_axis_tlast,   // last element of the sequence
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [ic_pkg::OUT_DW-1:0] o_m_axis_tdata    // [22:0] inversion_count,
                                                        // [23] overflowed
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int LW = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_SORT  = 2'd2;

    logic [1:0]                  r_phase, n_phase;
    logic [LW-1:0]               r_item_total, n_item_total;
    logic                        r_drop, n_drop;
    logic                        r_out_valid, n_out_valid;
    logic [ic_pkg::COUNT_W-1:0]  r_out_count, n_out_count;
    logic                        r_out_ovf, n_out_ovf;

    logic                        w_in_fire;
    logic                        w_room;
    logic                        w_load_we;
    logic                        w_out_free;
    ic_pkg::t_seq_cmd            w_cmd;
    ic_pkg::t_seq_stat           w_stat;
    ic_pkg::t_mem_ctl            w_mem;
    logic [AW-1:0]               w_rd_addr;
    logic [AW-1:0]               w_wr_addr;
    logic [VALUE_BITS-1:0]       w_wr_data;
    logic [ic_pkg::COUNT_W-1:0]  w_count;
    logic [VALUE_BITS-1:0]       w_rd_a;
    logic [VALUE_BITS-1:0]       w_rd_b;
    logic [VALUE_BITS-1:0]       w_rd_src;
    logic                        w_a_we;
    logic [AW-1:0]               w_a_addr;
    logic [VALUE_BITS-1:0]       w_a_data;
    logic                        w_b_we;

    // Accept elements only while loading; extra elements past capacity drop
    assign o_s_axis_tready = (r_phase == PH_LOAD);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_room          = r_item_total < LW'(MAX_ITEMS);
    assign w_load_we       = w_in_fire && w_room;

    // Hand the result over only when the output register is free
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_cmd.start = (r_phase == PH_START);
    assign w_cmd.ack   = (r_phase == PH_SORT) && w_stat.done && w_out_free;

    always_comb begin
        n_phase      = r_phase;
        n_item_total = r_item_total;
        n_drop       = r_drop;
        n_out_valid  = r_out_valid;
        n_out_count  = r_out_count;
        n_out_ovf    = r_out_ovf;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_phase)
            PH_LOAD: begin
                if (w_in_fire) begin
                    if (w_room) begin
                        n_item_total = r_item_total + LW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_phase = PH_START;
                    end
                end
            end
            PH_START: begin
                n_phase = PH_SORT;
            end
            PH_SORT: begin
                if (w_cmd.ack) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = w_count;
                    n_out_ovf    = r_drop;
                    n_item_total = '0;
                    n_drop       = 1'b0;
                    n_phase      = PH_LOAD;
                end
            end
            default: begin
                n_phase = PH_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LOAD;
            r_item_total <= '0;
            r_drop       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_item_total <= n_item_total;
            r_drop       <= n_drop;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    // Buffer A takes the incoming elements during load and merged output
    // on passes that target it; buffer B only takes merged output.
    assign w_a_we   = w_load_we || (w_mem.wr_en && !w_mem.wr_dst_b);
    assign w_a_addr = (r_phase == PH_LOAD) ? r_item_total[AW-1:0] : w_wr_addr;
    assign w_a_data = (r_phase == PH_LOAD) ? i_s_axis_tdata[VALUE_BITS-1:0] : w_wr_data;
    assign w_b_we   = w_mem.wr_en && w_mem.wr_dst_b;
    assign w_rd_src = w_mem.rd_src_b ? w_rd_b : w_rd_a;

    ic_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_buf_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_a_we),
        .i_wr_addr (w_a_addr),
        .i_wr_data (w_a_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_a)
    );

    ic_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_buf_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_b_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_b)
    );

    ic_merge_seq #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_merge_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_len     (r_item_total),
        .i_rd_data (w_rd_src),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_mem     (w_mem),
        .o_stat    (w_stat),
        .o_count   (w_count)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ovf, r_out_count};

endmodule
